### hw/rtl/spp_pkg.sv
// Shared types, constants and helpers of the scan point projector.
// Used by every RTL file of the block and by its checker.
package spp_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int ROTATOR_STAGES = 16;

  localparam int RANGE_W   = 16;
  localparam int ANG_W     = 16;
  localparam int BEAM_W    = 12;
  localparam int POSE_W    = 24;
  localparam int OUT_W     = 25;
  localparam int SUM_W     = OUT_W + 1;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int ANG_UP = (ANGLE_BITS > ANG_W) ? (ANGLE_BITS - ANG_W) : 0;
  localparam int ANG_DN = (ANGLE_BITS < ANG_W) ? (ANG_W - ANGLE_BITS) : 0;

  // Residual angle, one guard bit over the binary angle.
  localparam int ZW      = ANGLE_BITS + 1;
  // Rotator vector: 32-bit scaled range, gain growth and sign.
  localparam int DW      = 35;
  localparam int FRAC    = 16;
  localparam int RW      = DW - FRAC;
  localparam int STG_W   = (ROTATOR_STAGES > 1) ? $clog2(ROTATOR_STAGES) : 1;
  localparam int ATAN_N  = 24;
  localparam int ATAN_IW = $clog2(ATAN_N);

  localparam logic [31:0] KINV = 32'd2608131497;
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(8454143);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(8454144);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE   = 3'd0,
    REG_ANGLE_STEP    = 3'd1,
    REG_RANGE_FLOOR   = 3'd2,
    REG_RANGE_CEILING = 3'd3,
    REG_POSE_X        = 3'd4,
    REG_POSE_Y        = 3'd5,
    REG_POSE_HEADING  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [ANG_W-1:0]   start_angle;
    logic [ANG_W-1:0]   angle_step;
    logic [RANGE_W-1:0] range_floor;
    logic [RANGE_W-1:0] range_ceiling;
    logic [POSE_W-1:0]  pose_x;
    logic [POSE_W-1:0]  pose_y;
    logic [ANG_W-1:0]   pose_heading;
  } spp_cfg_t;

  // One point in flight through the rotator.
  typedef struct packed {
    logic [DW-1:0]     x;
    logic [DW-1:0]     y;
    logic [ZW-1:0]     z;
    logic [BEAM_W-1:0] beam;
  } spp_vec_t;

  // Arctangent of 2^-i in units of 2^-32 turn, truncated.
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  function automatic logic [ZW-1:0] atan_step(input logic [ATAN_IW-1:0] idx);
    return ZW'(ATAN_TAB[idx] >> (32 - ANGLE_BITS));
  endfunction

endpackage

### hw/rtl/spp_sample_if.sv
// Input channel of the scan point projector: one range sample per request.
// Depends on spp_pkg for field widths.
interface spp_sample_if
  import spp_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               first_of_scan;

  modport source (output valid, range_mm, first_of_scan, input ready);
  modport sink   (input valid, range_mm, first_of_scan, output ready);
endinterface

### hw/rtl/spp_point_if.sv
// Output channel of the scan point projector: one map point per request.
// Depends on spp_pkg for field widths.
interface spp_point_if
  import spp_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] map_x;
  logic signed [OUT_W-1:0] map_y;
  logic [BEAM_W-1:0]       beam_number;

  modport source (output valid, map_x, map_y, beam_number, input ready);
  modport sink   (input valid, map_x, map_y, beam_number, output ready);
endinterface

### hw/rtl/spp_front.sv
// Front end: beam angle tracking, range window, quadrant reduction,
// gain multiply and start vector. Depends on spp_pkg.
module spp_front
  import spp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  spp_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RANGE_W-1:0] range_mm,
  input  logic               first_of_scan,
  output logic               dn_valid,
  input  logic               dn_ready,
  output spp_vec_t           dn_data
);

  typedef struct packed {
    logic [RANGE_W-1:0] range;
    quad_t              quad;
    logic [ZW-1:0]      z;
    logic [BEAM_W-1:0]  beam;
  } s1_t;

  typedef struct packed {
    logic [31:0]       r;
    quad_t             quad;
    logic [ZW-1:0]     z;
    logic [BEAM_W-1:0] beam;
  } s2_t;

  logic [ANG_W-1:0]      beam_angle;
  logic [BEAM_W-1:0]     beam_count;
  logic [ANG_W-1:0]      ang;
  logic [ANG_W-1:0]      theta;
  logic [ANGLE_BITS-1:0] a;
  logic [ANGLE_BITS-1:0] a_round;
  logic [ANGLE_BITS-1:0] z_res;
  logic [BEAM_W-1:0]     cnt;
  logic                  in_window;
  logic                  accept;

  s1_t        s1, s1_next;
  s2_t        s2;
  logic       v1, v2, v3;
  logic       r1, r2, r3;
  logic [47:0] prod;
  logic [DW-1:0] r_ext;
  spp_vec_t   s3_next;

  assign accept = in_valid && in_ready;
  assign r3 = !v3 || dn_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    ang   = first_of_scan ? cfg.start_angle : beam_angle;
    cnt   = first_of_scan ? '0 : beam_count;
    theta = ang + cfg.pose_heading;
    if (ANGLE_BITS >= ANG_W) begin
      a = ANGLE_BITS'(theta) << ANG_UP;
    end else begin
      a = ANGLE_BITS'(theta >> ANG_DN);
    end
    // Nearest quadrant: residual falls in [-1/8, 1/8) turn.
    a_round = a + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
    z_res   = a - (ANGLE_BITS'(a_round[ANGLE_BITS-1 -: 2]) << (ANGLE_BITS - 2));
    in_window = (range_mm >= cfg.range_floor) && (range_mm <= cfg.range_ceiling);
    s1_next.range = range_mm;
    s1_next.quad  = quad_t'(a_round[ANGLE_BITS-1 -: 2]);
    s1_next.z     = {z_res[ANGLE_BITS-1], z_res};
    s1_next.beam  = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle <= '0;
      beam_count <= '0;
    end else if (accept) begin
      beam_angle <= ang + cfg.angle_step;
      beam_count <= cnt + BEAM_W'(1);
    end
  end

  // Stage 1: reduced angle; rejected samples leave no entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= accept && in_window;
    end
  end
  always_ff @(posedge clk) begin
    if (r1 && accept) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: range scaled by the inverse rotator gain.
  assign prod = 48'(s1.range) * 48'(KINV);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      s2.r    <= prod[47:16];
      s2.quad <= s1.quad;
      s2.z    <= s1.z;
      s2.beam <= s1.beam;
    end
  end

  // Stage 3: start vector on the chosen axis.
  assign r_ext = DW'(s2.r);

  always_comb begin
    s3_next.z    = s2.z;
    s3_next.beam = s2.beam;
    unique case (s2.quad)
      QUAD_0: begin
        s3_next.x = r_ext;
        s3_next.y = '0;
      end
      QUAD_90: begin
        s3_next.x = '0;
        s3_next.y = r_ext;
      end
      QUAD_180: begin
        s3_next.x = -r_ext;
        s3_next.y = '0;
      end
      QUAD_270: begin
        s3_next.x = '0;
        s3_next.y = -r_ext;
      end
      default: begin
        s3_next.x = '0;
        s3_next.y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      dn_data <= s3_next;
    end
  end

  assign dn_valid = v3;

endmodule

### hw/rtl/spp_cell.sv
// One rotator cell: a single shift-add micro-rotation, registered.
// Depends on spp_pkg.
module spp_cell
  import spp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [STG_W-1:0] stage,
  input  logic             up_valid,
  output logic             up_ready,
  input  spp_vec_t         up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output spp_vec_t         dn_data
);

  logic signed [DW-1:0] xs, ys;
  logic [ZW-1:0]        t;
  spp_vec_t             nxt;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    xs = $signed(up_data.x) >>> stage;
    ys = $signed(up_data.y) >>> stage;
    t  = atan_step(ATAN_IW'(stage));
    nxt.beam = up_data.beam;
    if (!up_data.z[ZW-1]) begin
      nxt.x = up_data.x - ys;
      nxt.y = up_data.y + xs;
      nxt.z = up_data.z - t;
    end else begin
      nxt.x = up_data.x + ys;
      nxt.y = up_data.y - xs;
      nxt.z = up_data.z + t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule

### hw/rtl/spp_back.sv
// Back end: rounding to millimetres, pose offset, saturation and the
// output register. Depends on spp_pkg.
module spp_back
  import spp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  spp_cfg_t                cfg,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  spp_vec_t                up_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] map_x,
  output logic signed [OUT_W-1:0] map_y,
  output logic [BEAM_W-1:0]       beam_number
);

  localparam logic [DW-1:0] HALF = DW'(1) << (FRAC - 1);

  logic                 vr, rr, ro;
  logic [RW-1:0]        rx, ry;
  logic [BEAM_W-1:0]    rbeam;
  logic [DW-1:0]        sx, sy;
  logic signed [SUM_W-1:0] px, py;

  assign ro = !out_valid || out_ready;
  assign rr = !vr || ro;
  assign up_ready = rr;

  // Round half up to whole millimetres.
  assign sx = up_data.x + HALF;
  assign sy = up_data.y + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (rr) begin
      vr <= up_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (rr && up_valid) begin
      rx    <= sx[DW-1:FRAC];
      ry    <= sy[DW-1:FRAC];
      rbeam <= up_data.beam;
    end
  end

  assign px = SUM_W'($signed(cfg.pose_x)) + SUM_W'($signed(rx));
  assign py = SUM_W'($signed(cfg.pose_y)) + SUM_W'($signed(ry));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ro) begin
      out_valid <= vr;
    end
  end
  always_ff @(posedge clk) begin
    if (ro && vr) begin
      map_x <= (px > OUT_MAX) ? OUT_W'(OUT_MAX) :
               (px < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(px);
      map_y <= (py > OUT_MAX) ? OUT_W'(OUT_MAX) :
               (py < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(py);
      beam_number <= rbeam;
    end
  end

endmodule

### hw/rtl/scan_point_projector_unit.sv
// Scan point projector: turns a stream of laser range samples into map
// points. Each sample is taken at the beam angle tracked here (reloaded
// from start_angle when first_of_scan is set, then advanced by angle_step
// per sample, kept or not), rotated by angle + pose_heading through a
// chain of ROTATOR_STAGES shift-add cells and offset by the pose. Samples
// outside [range_floor, range_ceiling] produce no point but still advance
// the beam angle and beam number. Throughput is one sample per clock while
// the output side is ready; a sample passes the front end stages, the
// rotator cells and the back end rounding and output registers. Every
// stage has its own ready, so bubbles close up under output backpressure
// and requests keep being taken while stages are free. The user writes
// configuration through cfg_write/cfg_index/cfg_data while the block is idle;
// the block does not enforce it. Indexes beyond the register list are ignored.
module scan_point_projector_unit
  import spp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  spp_sample_if.sink           samples,
  spp_point_if.source          points
);

  spp_cfg_t cfg;

  // Chain links: index 0 is the front end output, the last feeds the back end.
  logic     link_valid [ROTATOR_STAGES+1];
  logic     link_ready [ROTATOR_STAGES+1];
  spp_vec_t link_data  [ROTATOR_STAGES+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_angle   <= '0;
      cfg.angle_step    <= '0;
      cfg.range_floor   <= '0;
      cfg.range_ceiling <= '1;
      cfg.pose_x        <= '0;
      cfg.pose_y        <= '0;
      cfg.pose_heading  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_ANGLE:   cfg.start_angle   <= cfg_data[ANG_W-1:0];
        REG_ANGLE_STEP:    cfg.angle_step    <= cfg_data[ANG_W-1:0];
        REG_RANGE_FLOOR:   cfg.range_floor   <= cfg_data[RANGE_W-1:0];
        REG_RANGE_CEILING: cfg.range_ceiling <= cfg_data[RANGE_W-1:0];
        REG_POSE_X:        cfg.pose_x        <= cfg_data[POSE_W-1:0];
        REG_POSE_Y:        cfg.pose_y        <= cfg_data[POSE_W-1:0];
        REG_POSE_HEADING:  cfg.pose_heading  <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  spp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .range_mm     (samples.range_mm),
    .first_of_scan(samples.first_of_scan),
    .dn_valid     (link_valid[0]),
    .dn_ready     (link_ready[0]),
    .dn_data      (link_data[0])
  );

  // Rotator: cell g applies the micro-rotation with shift g.
  for (genvar g = 0; g < ROTATOR_STAGES; g++) begin : g_cell
    spp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .stage   (STG_W'(g)),
      .up_valid(link_valid[g]),
      .up_ready(link_ready[g]),
      .up_data (link_data[g]),
      .dn_valid(link_valid[g+1]),
      .dn_ready(link_ready[g+1]),
      .dn_data (link_data[g+1])
    );
  end

  spp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (link_valid[ROTATOR_STAGES]),
    .up_ready   (link_ready[ROTATOR_STAGES]),
    .up_data    (link_data[ROTATOR_STAGES]),
    .out_valid  (points.valid),
    .out_ready  (points.ready),
    .map_x      (points.map_x),
    .map_y      (points.map_y),
    .beam_number(points.beam_number)
  );

endmodule

### hw/rtl/spp_checker.sv
// Port-level checks of the scan point projector, bound to its top level.
// Depends on spp_pkg and the top level's channel ports.
module spp_checker
  import spp_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] map_x,
  input logic signed [OUT_W-1:0] map_y,
  input logic [BEAM_W-1:0]       beam_number
);

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("point request right after reset");

  // A free output register frees the whole chain for a new sample.
  a_free_in: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("sample refused with free output");

  // Points stay inside the saturation window.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SUM_W'(map_x) <= OUT_MAX) && (SUM_W'(map_x) >= OUT_MIN) &&
                  (SUM_W'(map_y) <= OUT_MAX) && (SUM_W'(map_y) >= OUT_MIN))
    else $error("point outside saturation window");

  // A stalled point holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(map_x) && $stable(map_y) &&
                                $stable(beam_number))
    else $error("stalled point changed");

endmodule

bind scan_point_projector_unit spp_checker u_spp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (samples.ready),
  .out_valid  (points.valid),
  .out_ready  (points.ready),
  .map_x      (points.map_x),
  .map_y      (points.map_y),
  .beam_number(points.beam_number)
);
